>>> hw/rtl/morse_symbol_keyer_defines.svh
// Assertion macros for the Morse keyer.
`ifndef MORSE_SYMBOL_KEYER_DEFINES_SVH
`define MORSE_SYMBOL_KEYER_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset
`define MSK_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("keyer assertion failed");
// Implication checked in the cycle after the antecedent
`define MSK_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("keyer assertion failed");
`else
`define MSK_ASSERT(lbl, clk, rstn, prop)
`define MSK_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

>>> hw/rtl/msk_pkg.sv
package msk_pkg;

  // Element limit per symbol and derived widths
  localparam int MaxElements = 5;
  localparam int LenW        = $clog2(MaxElements + 1);
  localparam int IdxW        = 3;
  localparam int TimeW       = 16;
  localparam int SymW        = 6;
  localparam int CfgIdxW     = 2;

  // Highest valid symbol code (letter Z)
  localparam logic [SymW-1:0] SymLast = 6'd35;

  // Operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDot      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDash     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegElemGap  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRepGap   = 2'd3;

  // Register reset values
  localparam logic [TimeW-1:0] DotReset     = 16'd100;
  localparam logic [TimeW-1:0] DashReset    = 16'd500;
  localparam logic [TimeW-1:0] ElemGapReset = 16'd100;
  localparam logic [TimeW-1:0] RepGapReset  = 16'd500;

  typedef struct packed {
    logic            operation;
    logic [SymW-1:0] symbol;
    logic            play_twice;
  } in_item_t;

  typedef struct packed {
    logic tone_on;
    logic busy_res;
    logic accepted;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0] dot_ticks;
    logic [TimeW-1:0] dash_ticks;
    logic [TimeW-1:0] element_gap_ticks;
    logic [TimeW-1:0] repeat_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic [4:0] pattern;  // bit i set: element i is a dash
    logic [2:0] len;
  } sym_code_t;

  // Dot/dash table: digits 0-9, then letters A-Z
  function automatic sym_code_t sym_lookup(logic [SymW-1:0] sym);
    sym_code_t c;
    c = '0;
    case (sym)
      6'd0:  c = '{5'h1F, 3'd5};
      6'd1:  c = '{5'h1E, 3'd5};
      6'd2:  c = '{5'h1C, 3'd5};
      6'd3:  c = '{5'h18, 3'd5};
      6'd4:  c = '{5'h10, 3'd5};
      6'd5:  c = '{5'h00, 3'd5};
      6'd6:  c = '{5'h01, 3'd5};
      6'd7:  c = '{5'h03, 3'd5};
      6'd8:  c = '{5'h07, 3'd5};
      6'd9:  c = '{5'h0F, 3'd5};
      6'd10: c = '{5'h02, 3'd2};
      6'd11: c = '{5'h01, 3'd4};
      6'd12: c = '{5'h05, 3'd4};
      6'd13: c = '{5'h01, 3'd3};
      6'd14: c = '{5'h00, 3'd1};
      6'd15: c = '{5'h04, 3'd4};
      6'd16: c = '{5'h03, 3'd3};
      6'd17: c = '{5'h00, 3'd4};
      6'd18: c = '{5'h00, 3'd2};
      6'd19: c = '{5'h0E, 3'd4};
      6'd20: c = '{5'h05, 3'd3};
      6'd21: c = '{5'h02, 3'd4};
      6'd22: c = '{5'h03, 3'd2};
      6'd23: c = '{5'h01, 3'd2};
      6'd24: c = '{5'h07, 3'd3};
      6'd25: c = '{5'h06, 3'd4};
      6'd26: c = '{5'h0B, 3'd4};
      6'd27: c = '{5'h02, 3'd3};
      6'd28: c = '{5'h00, 3'd3};
      6'd29: c = '{5'h01, 3'd1};
      6'd30: c = '{5'h04, 3'd3};
      6'd31: c = '{5'h08, 3'd4};
      6'd32: c = '{5'h06, 3'd3};
      6'd33: c = '{5'h09, 3'd4};
      6'd34: c = '{5'h0D, 3'd4};
      6'd35: c = '{5'h03, 3'd4};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/msk_core.sv
`include "morse_symbol_keyer_defines.svh"

module msk_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  msk_pkg::in_item_t   item_i,
  input  msk_pkg::cfg_t       cfg_i,
  output msk_pkg::out_item_t  res_o
);

  // Phase codes
  localparam logic [1:0] PhTone   = 2'd0;
  localparam logic [1:0] PhGap    = 2'd1;
  localparam logic [1:0] PhRepeat = 2'd2;

  logic                         active_q, active_d;
  logic                         pend_q, pend_d;
  logic [1:0]                   phase_q, phase_d;
  logic [4:0]                   pattern_q, pattern_d;
  logic [msk_pkg::LenW-1:0]     length_q, length_d;
  logic [msk_pkg::IdxW-1:0]     idx_q, idx_d, idx_inc;
  logic [msk_pkg::TimeW-1:0]    time_q, time_d;
  logic [7:0]                   pat_ext;
  msk_pkg::sym_code_t           code;
  logic [msk_pkg::LenW-1:0]     code_len;
  logic                         start_ok;

  // Table lookup and length clamp for a start
  assign code     = msk_pkg::sym_lookup(item_i.symbol);
  assign code_len = (int'(code.len) > msk_pkg::MaxElements)
                    ? msk_pkg::LenW'(msk_pkg::MaxElements)
                    : msk_pkg::LenW'(code.len);
  assign start_ok = (item_i.operation == msk_pkg::OpStart) && !active_q
                    && (item_i.symbol <= msk_pkg::SymLast);
  assign pat_ext  = {3'b000, pattern_q};
  assign idx_inc  = idx_q + msk_pkg::IdxW'(1);

  // Next state for one item
  always_comb begin
    active_d  = active_q;
    pend_d    = pend_q;
    phase_d   = phase_q;
    pattern_d = pattern_q;
    length_d  = length_q;
    idx_d     = idx_q;
    time_d    = time_q;
    if (start_ok) begin
      pattern_d = code.pattern;
      length_d  = code_len;
      idx_d     = '0;
      phase_d   = PhTone;
      pend_d    = item_i.play_twice;
      active_d  = 1'b1;
      time_d    = code.pattern[0] ? cfg_i.dash_ticks : cfg_i.dot_ticks;
    end else if (item_i.operation == msk_pkg::OpTick && active_q) begin
      if (time_q > msk_pkg::TimeW'(1)) begin
        time_d = time_q - msk_pkg::TimeW'(1);
      end else begin
        unique case (phase_q)
          PhTone: begin
            phase_d = PhGap;
            time_d  = cfg_i.element_gap_ticks;
          end
          PhGap: begin
            idx_d = idx_inc;
            if (msk_pkg::LenW'(idx_inc) < length_q) begin
              phase_d = PhTone;
              time_d  = pat_ext[idx_inc] ? cfg_i.dash_ticks : cfg_i.dot_ticks;
            end else if (pend_q) begin
              pend_d  = 1'b0;
              phase_d = PhRepeat;
              time_d  = cfg_i.repeat_gap_ticks;
            end else begin
              active_d = 1'b0;
              phase_d  = PhTone;
              time_d   = '0;
            end
          end
          PhRepeat: begin
            idx_d   = '0;
            phase_d = PhTone;
            time_d  = pattern_q[0] ? cfg_i.dash_ticks : cfg_i.dot_ticks;
          end
          default: begin
            active_d = 1'b0;
            phase_d  = PhTone;
            time_d   = '0;
            pend_d   = 1'b0;
          end
        endcase
      end
    end
  end

  // Result of this item
  assign res_o.tone_on  = active_d && (phase_d == PhTone);
  assign res_o.busy_res = active_d;
  assign res_o.accepted = start_ok;

  // Keyer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      pend_q    <= 1'b0;
      phase_q   <= PhTone;
      pattern_q <= '0;
      length_q  <= '0;
      idx_q     <= '0;
      time_q    <= '0;
    end else if (step_i) begin
      active_q  <= active_d;
      pend_q    <= pend_d;
      phase_q   <= phase_d;
      pattern_q <= pattern_d;
      length_q  <= length_d;
      idx_q     <= idx_d;
      time_q    <= time_d;
    end
  end

  // Idle keyer sits in tone phase with a cleared timer
  `MSK_ASSERT(a_idle_clean, clk_i, rst_ni,
    !active_q |-> (phase_q == PhTone && time_q == '0 && !pend_q))
  // While an element is running its index stays inside the symbol
  `MSK_ASSERT(a_idx_in_range, clk_i, rst_ni,
    (active_q && phase_q != PhRepeat) |-> (idx_q < msk_pkg::IdxW'(length_q)))
  // A start while busy is never taken and leaves the pattern alone
  `MSK_ASSERT_NEXT(a_busy_start_ignored, clk_i, rst_ni,
    step_i && active_q && item_i.operation == msk_pkg::OpStart,
    $stable(pattern_q) && $stable(pend_q))

endmodule

>>> hw/rtl/morse_symbol_keyer.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid_i/in_stall_o   | in_data_i  (operation, symbol, play_twice)
// out     | out | out_valid_o/out_stall_i | out_data_o (tone_on, busy_res, accepted)
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each item passes from transfer to result through the input register, then
// through the keyer step into the result register. One item per cycle is
// sustained unless the result stalls; the keyer state update is the only loop.
// Reset is asynchronous; all registers but in_q and out_q come out at their defaults.
// A stalled result holds while an empty input register still takes one more item.
module morse_symbol_keyer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  msk_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output msk_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [msk_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [msk_pkg::TimeW-1:0]   cfg_data_i
);

  logic                in_valid_q;
  msk_pkg::in_item_t   in_q;
  logic                out_valid_q;
  msk_pkg::out_item_t  out_q;
  msk_pkg::cfg_t       cfg_q;
  msk_pkg::out_item_t  res;
  logic                advance;
  logic                step;

  // Pipeline movement
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dot_ticks         <= msk_pkg::DotReset;
      cfg_q.dash_ticks        <= msk_pkg::DashReset;
      cfg_q.element_gap_ticks <= msk_pkg::ElemGapReset;
      cfg_q.repeat_gap_ticks  <= msk_pkg::RepGapReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        msk_pkg::RegDot:     cfg_q.dot_ticks         <= cfg_data_i;
        msk_pkg::RegDash:    cfg_q.dash_ticks        <= cfg_data_i;
        msk_pkg::RegElemGap: cfg_q.element_gap_ticks <= cfg_data_i;
        msk_pkg::RegRepGap:  cfg_q.repeat_gap_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Keyer state and step logic
  msk_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
